@@ sv/first_fit_block_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the first-fit block allocator
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ sv/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// types and codes shared by the first-fit block allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned FIELD_BITS = 20;

  localparam logic       MODE_ALLOC = 1'b0;
  localparam logic       MODE_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] request_size;
    logic [FIELD_BITS-1:0] address;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] payload_address;
    logic [2:0]            status;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

endpackage

@@ sv/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell
// one table entry; compares the travelling request and claims it on a hit
// ----------------------------------------------------------------------------
module ffa_cell #(
  parameter int unsigned AW = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             mode,
  input  logic [AW:0]      size_q,
  input  logic [AW-1:0]    addr_q,
  input  logic [AW-1:0]    hdr,
  input  ffa_pkg::tok_t    tok_in,
  output ffa_pkg::tok_t    tok_out,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_start,
  input  logic [AW:0]      wr_size,
  output logic             hit,
  output logic             dbl,
  output logic [AW-1:0]    hit_payload
);

  logic          used_r, used_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] start_r;
  logic [AW:0]   size_r;
  logic          match;
  ffa_pkg::tok_t tok_r;

  // entry match for the request passing through
  always_comb begin
    if (mode == ffa_pkg::MODE_ALLOC) begin
      match = used_r && free_r && (size_r >= size_q);
    end else begin
      match = used_r && (start_r + hdr == addr_q);
    end
    hit         = tok_in.valid && !tok_in.found && match;
    dbl         = hit && (mode == ffa_pkg::MODE_FREE) && free_r;
    hit_payload = start_r + hdr;
  end

  // entry state update
  always_comb begin
    used_nxt = used_r;
    free_nxt = free_r;
    if (wr_en) begin
      used_nxt = 1'b1;
      free_nxt = 1'b0;
    end else if (hit) begin
      free_nxt = (mode == ffa_pkg::MODE_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      free_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      used_r <= used_nxt;
      free_r <= free_nxt;
      tok_r  <= clr ? ffa_pkg::tok_t'('0)
                    : ffa_pkg::tok_t'{valid: tok_in.valid, found: tok_in.found | hit};
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_r <= wr_start;
      size_r  <= wr_size;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ sv/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl
// request sequencer: latches a beat, times the scan and forms the result
// ----------------------------------------------------------------------------
module ffa_ctrl #(
  parameter int unsigned N  = 64,
  parameter int unsigned AW = 20,
  parameter int unsigned HB = 32,
  parameter int unsigned AB = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffa_pkg::in_beat_t  in_beat,
  input  logic [AW:0]        limit,
  input  logic               any_hit,
  input  logic               any_dbl,
  input  logic [AW-1:0]      hit_pay,
  output logic               seed,
  output logic               clr,
  output logic               mode,
  output logic [AW:0]        size_q,
  output logic [AW-1:0]      addr_q,
  output logic [$clog2(N+1)-1:0] count,
  output logic               wr_any,
  output logic [AW-1:0]      wr_start,
  output logic               out_valid,
  output ffa_pkg::out_beat_t out_beat
);

  localparam int unsigned CW = $clog2(N+1);

  ffa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   step_r, count_r;
  logic [AW:0]     top_r;
  logic            mode_r, found_r, dbl_r;
  logic [AW:0]     size_r;
  logic [AW-1:0]   addr_r, pay_r;
  logic [AW:0]     lim_eff;
  logic [AW+1:0]   end_w, req_w;
  logic            zero_w, done_w, app_ok;
  logic            launch;
  logic            ov_r;
  ffa_pkg::out_beat_t ob_r;

  assign req_w   = {2'b00, in_beat.request_size[AW-1:0]} + (AW+2)'(AB - 1);
  assign lim_eff = (limit > (AW+1)'(1 << AW)) ? (AW+1)'(1 << AW) : limit;
  assign end_w   = {1'b0, top_r} + (AW+2)'(HB) + {1'b0, size_r};
  assign app_ok  = (count_r < CW'(N)) && (end_w <= {1'b0, lim_eff});
  assign zero_w  = (mode_r == ffa_pkg::MODE_ALLOC) ? (size_r == '0)
                                                   : (addr_r == '0);
  assign done_w  = (step_r == CW'(N));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffa_pkg::S_IDLE: if (start) state_nxt = ffa_pkg::S_SCAN;
      ffa_pkg::S_SCAN: if (done_w || zero_w) state_nxt = ffa_pkg::S_DONE;
      ffa_pkg::S_DONE: state_nxt = ffa_pkg::S_IDLE;
      default:         state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_r != ffa_pkg::S_IDLE);
    launch = (state_r == ffa_pkg::S_IDLE) && start;
    clr    = launch;
    // token enters cell 0 in the first scan cycle, once the request is latched
    seed   = (state_r == ffa_pkg::S_SCAN) && (step_r == '0) && !zero_w;
    wr_any = (state_r == ffa_pkg::S_SCAN) && done_w && !zero_w && !found_r
             && !any_hit && (mode_r == ffa_pkg::MODE_ALLOC) && app_ok;
  end

  assign mode     = mode_r;
  assign size_q   = size_r;
  assign addr_q   = addr_r;
  assign count    = count_r;
  assign wr_start = top_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
      step_r  <= '0;
      count_r <= '0;
      top_r   <= '0;
      found_r <= 1'b0;
      dbl_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      if (launch) begin
        step_r  <= '0;
        found_r <= 1'b0;
        dbl_r   <= 1'b0;
      end else if (state_r == ffa_pkg::S_SCAN) begin
        step_r <= step_r + 1'b1;
        if (any_hit && !found_r) begin
          found_r <= 1'b1;
          dbl_r   <= any_dbl;
        end
        if (zero_w || done_w) begin
          ov_r <= 1'b1;
          if (zero_w) begin
            ob_r.status <= (mode_r == ffa_pkg::MODE_ALLOC) ? ffa_pkg::ST_ZERO
                                                           : ffa_pkg::ST_OK;
            ob_r.payload_address <= '0;
          end else if (found_r || any_hit) begin
            ob_r.status <= (dbl_r || (!found_r && any_dbl)) ? ffa_pkg::ST_DOUBLE
                                                            : ffa_pkg::ST_OK;
            ob_r.payload_address <= (mode_r == ffa_pkg::MODE_ALLOC)
                                    ? (found_r ? pay_r : hit_pay) : '0;
          end else if (mode_r == ffa_pkg::MODE_FREE) begin
            ob_r.status          <= ffa_pkg::ST_INVALID;
            ob_r.payload_address <= '0;
          end else if (app_ok) begin
            ob_r.status          <= ffa_pkg::ST_OK;
            ob_r.payload_address <= top_r[AW-1:0] + AW'(HB);
            count_r              <= count_r + 1'b1;
            top_r                <= end_w[AW:0];
          end else begin
            ob_r.status          <= ffa_pkg::ST_NOSPACE;
            ob_r.payload_address <= '0;
          end
        end
      end
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (launch) begin
      mode_r <= in_beat.mode;
      addr_r <= in_beat.address[AW-1:0];
      size_r <= (AW+1)'((req_w >> $clog2(AB)) << $clog2(AB));
    end
    if (state_r == ffa_pkg::S_SCAN && any_hit && !found_r) pay_r <= hit_pay;
  end

  assign out_valid = ov_r;
  assign out_beat  = ob_r;

endmodule

@@ sv/first_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit heap block allocator built as a row of table cells
// ----------------------------------------------------------------------------
// Pulse start with busy low to send a request beat. A token walks the row of
// MAX_BLOCKS cells, one cell per cycle; a zero-size allocate or a free of
// address zero skips the walk. The walk length is set by the step counter in
// ffa_ctrl. The result beat appears on out_valid for one cycle and cannot be
// stalled. The user must write heap_limit through cfg_we/cfg_wdata only while
// busy is low; the block itself does not enforce this.
`include "first_fit_block_allocator_top_defines.svh"
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ffa_pkg::in_beat_t               in_beat,
  output logic                            out_valid,
  output ffa_pkg::out_beat_t              out_beat,
  input  logic                            cfg_we,
  input  logic [ffa_pkg::FIELD_BITS:0]    cfg_wdata
);

  localparam int unsigned N  = MAX_BLOCKS;
  localparam int unsigned AW = ffa_pkg::FIELD_BITS;
  localparam int unsigned CW = $clog2(N+1);

  logic [AW:0]    limit_r;
  logic           seed, clr, mode, wr_any, any_hit, any_dbl;
  logic [AW:0]    size_q;
  logic [AW-1:0]  addr_q, wr_start, hit_pay;
  logic [CW-1:0]  count;
  ffa_pkg::tok_t  tok [N+1];
  logic [N-1:0]   hit_v, dbl_v;
  logic [AW-1:0]  pay_v [N];

  // heap limit register
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= (AW+1)'(1 << AW);
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  ffa_ctrl #(.N(N), .AW(AW), .HB(HEADER_BYTES), .AB(ALIGN_BYTES)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_beat, .limit(limit_r),
    .any_hit, .any_dbl, .hit_pay, .seed, .clr, .mode, .size_q, .addr_q,
    .count, .wr_any, .wr_start, .out_valid, .out_beat
  );

  assign tok[0] = ffa_pkg::tok_t'{valid: seed, found: 1'b0};

  // cell row
  for (genvar g = 0; g < N; g++) begin : g_cell
    ffa_cell #(.AW(AW)) u_cell (
      .clk, .rst_n, .clr, .mode, .size_q, .addr_q,
      .hdr(AW'(HEADER_BYTES)),
      .tok_in(tok[g]), .tok_out(tok[g+1]),
      .wr_en(wr_any && (count == CW'(g))),
      .wr_start, .wr_size(size_q),
      .hit(hit_v[g]), .dbl(dbl_v[g]), .hit_payload(pay_v[g])
    );
  end

  // only one cell holds the token at a time
  always_comb begin
    hit_pay = '0;
    for (int i = 0; i < N; i++) if (hit_v[i]) hit_pay = pay_v[i];
  end
  assign any_hit = |hit_v;
  assign any_dbl = |dbl_v;

  `FFA_ASSERT_IMPL(a_one_hit, clk, rst_n, 1'b1, $onehot0(hit_v))
  `FFA_ASSERT_NEXT(a_busy_on_start, clk, rst_n, start && !busy, busy)
  `FFA_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, busy)

endmodule
